// File: design/log_segment_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the log segment block allocator checks.
// Each macro names a clock, a disable condition, a trigger and a consequence.
// ----------------------------------------------------------------------------
`ifndef LOG_SEGMENT_BLOCK_ALLOCATOR_ASSERT_SVH
`define LOG_SEGMENT_BLOCK_ALLOCATOR_ASSERT_SVH

// The consequence must hold in the same cycle as the trigger.
`define LSBA_ASSERT_NOW(lbl, ck, dis, trig, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (trig) |-> (cons)) \
    else $error("allocator check failed");

// The consequence must hold in the cycle after the trigger.
`define LSBA_ASSERT_NEXT(lbl, ck, dis, trig, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (trig) |=> (cons)) \
    else $error("allocator check failed");

`endif

// File: design/lsba_pkg.sv
// ----------------------------------------------------------------------------
// lsba_pkg
// Shared widths, codes and structs of the log segment block allocator.
// ----------------------------------------------------------------------------
package lsba_pkg;

  localparam int SLOTS_PER_SEGMENT_DEF = 31;
  localparam int SEGMENT_COUNT_DEF     = 64;

  // Widths of the transaction fields.
  localparam int SEG_FIELD_W  = 6;
  localparam int SLOT_FIELD_W = 5;
  // Internal slot index width, wide enough for the largest segment.
  localparam int SLOT_IDX_W   = 6;

  typedef enum logic [1:0] {
    STATUS_PLACED    = 2'd0,
    STATUS_REWRITTEN = 2'd1,
    STATUS_NO_SPACE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    UNIT_NOP,
    UNIT_FIND,
    UNIT_APPLY
  } unit_op_t;

  typedef struct packed {
    unit_op_t                op;
    logic                    has_old;
    logic [SEG_FIELD_W-1:0]  old_segment;
    logic [SLOT_FIELD_W-1:0] old_slot;
  } unit_cmd_t;

  typedef struct packed {
    logic [SEG_FIELD_W-1:0] cur_seg;
    logic                   last;
    logic                   hit;
    logic                   found;
    logic [SLOT_IDX_W-1:0]  free_idx;
  } unit_res_t;

endpackage

// File: design/lsba_req_if.sv
// ----------------------------------------------------------------------------
// lsba_req_if
// Request channel: one block placement per transaction.
// ----------------------------------------------------------------------------
interface lsba_req_if import lsba_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    has_old;
  logic [SEG_FIELD_W-1:0]  old_segment;
  logic [SLOT_FIELD_W-1:0] old_slot;

  modport source (output valid, has_old, old_segment, old_slot, input ready);
  modport sink   (input valid, has_old, old_segment, old_slot, output ready);
endinterface

// File: design/lsba_rsp_if.sv
// ----------------------------------------------------------------------------
// lsba_rsp_if
// Response channel: one placement result per transaction.
// ----------------------------------------------------------------------------
interface lsba_rsp_if import lsba_pkg::*; ();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic [SEG_FIELD_W-1:0]  block_segment;
  logic [SLOT_FIELD_W-1:0] block_slot;
  logic [SEG_FIELD_W-1:0]  summary_segment;
  logic [SLOT_FIELD_W-1:0] summary_slot;
  logic                    segment_switched;

  modport source (output valid, status, block_segment, block_slot, summary_segment,
                  summary_slot, segment_switched, input ready);
  modport sink   (input valid, status, block_segment, block_slot, summary_segment,
                  summary_slot, segment_switched, output ready);
endinterface

// File: design/lsba_slot_unit.sv
// ----------------------------------------------------------------------------
// lsba_slot_unit
// Shared placement unit: holds the current segment's liveness row, finds the
// first free slot, and applies one placement, switch or flush per command.
// ----------------------------------------------------------------------------
module lsba_slot_unit import lsba_pkg::*; #(
  parameter int SLOTS_PER_SEGMENT = SLOTS_PER_SEGMENT_DEF,
  parameter int SEGMENT_COUNT     = SEGMENT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  unit_cmd_t cmd,
  output unit_res_t res
);

  localparam int SEG_W = $clog2(SEGMENT_COUNT);

  typedef enum logic [1:0] {
    LIVE_FREE      = 2'd0,
    LIVE_UNFLUSHED = 2'd1,
    LIVE_FLUSHED   = 2'd2
  } live_t;

  live_t                 row      [SLOTS_PER_SEGMENT];
  live_t                 row_next [SLOTS_PER_SEGMENT];
  logic [SEG_W-1:0]      cur;
  logic [SEG_W-1:0]      cur_next;
  logic [SEG_W-1:0]      cur_inc;
  logic                  last;
  logic                  hit;
  logic                  found;
  logic [SLOT_IDX_W-1:0] idx;
  logic                  hit_c;
  logic                  found_c;
  logic [SLOT_IDX_W-1:0] idx_c;
  logic                  old_here;
  logic                  old_in_next;

  assign cur_inc     = cur + 1'b1;
  assign last        = (cur == SEG_W'(SEGMENT_COUNT - 1));
  assign old_here    = cmd.has_old && (cmd.old_segment == SEG_FIELD_W'(cur));
  assign old_in_next = cmd.has_old && (cmd.old_segment == SEG_FIELD_W'(cur_inc));

  // Rewrite check and first-free search over the registered row.
  always_comb begin
    hit_c   = 1'b0;
    found_c = 1'b0;
    idx_c   = '0;
    for (int i = 0; i < SLOTS_PER_SEGMENT; i++) begin
      if (old_here && int'(cmd.old_slot) == i && row[i] == LIVE_UNFLUSHED) begin
        hit_c = 1'b1;
      end
    end
    for (int i = SLOTS_PER_SEGMENT - 1; i >= 0; i--) begin
      if (row[i] == LIVE_FREE) begin
        found_c = 1'b1;
        idx_c   = SLOT_IDX_W'(i);
      end
    end
  end

  // Placement: take the free slot, or move to a fresh segment, or flush when
  // the log is exhausted. The old home is freed after the new slot is taken.
  always_comb begin
    row_next = row;
    cur_next = cur;
    if (!hit) begin
      if (found) begin
        for (int i = 0; i < SLOTS_PER_SEGMENT; i++) begin
          if (SLOT_IDX_W'(i) == idx) begin
            row_next[i] = LIVE_UNFLUSHED;
          end
          if (old_here && int'(cmd.old_slot) == i) begin
            row_next[i] = LIVE_FREE;
          end
        end
      end else if (!last) begin
        cur_next = cur_inc;
        for (int i = 0; i < SLOTS_PER_SEGMENT; i++) begin
          row_next[i] = (i == 0) ? LIVE_UNFLUSHED : LIVE_FREE;
          if (old_in_next && int'(cmd.old_slot) == i) begin
            row_next[i] = LIVE_FREE;
          end
        end
      end else begin
        for (int i = 0; i < SLOTS_PER_SEGMENT; i++) begin
          if (row[i] == LIVE_UNFLUSHED) begin
            row_next[i] = LIVE_FLUSHED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS_PER_SEGMENT; i++) begin
        row[i] <= (i == 0) ? LIVE_UNFLUSHED : LIVE_FREE;
      end
      cur   <= '0;
      hit   <= 1'b0;
      found <= 1'b0;
      idx   <= '0;
    end else begin
      case (cmd.op)
        UNIT_FIND: begin
          hit   <= hit_c;
          found <= found_c;
          idx   <= idx_c;
        end
        UNIT_APPLY: begin
          row <= row_next;
          cur <= cur_next;
        end
        default: begin
        end
      endcase
    end
  end

  assign res.cur_seg  = SEG_FIELD_W'(cur);
  assign res.last     = last;
  assign res.hit      = hit;
  assign res.found    = found;
  assign res.free_idx = idx;

endmodule

// File: design/log_segment_block_allocator.sv
// ----------------------------------------------------------------------------
// log_segment_block_allocator
// Places blocks and the summary block in a segmented log, one request at a time.
// ----------------------------------------------------------------------------
// Usage: a request transaction on req carries has_old, old_segment and
// old_slot; each one yields exactly one response transaction on rsp with the
// status, the block's new home, the summary location and a switch flag.
// Requests are taken one at a time: req.ready is high only while the
// sequencer is idle. A normal request runs accept, find and apply for the
// block, find and apply for the summary, then load the result before the
// next acceptance; a request that is rewritten in place, or whose block
// finds no segment left, skips the summary's find and apply, and a request
// that finds the log already out of space goes from accept straight to the
// result. The single shared placement unit needs a find step and an apply
// step for each placement.
// The response sits in an output register, so a new request is accepted
// while an earlier response waits; if the receiver still stalls when the
// next result is ready, the sequencer holds in its result state.
// Reset (synchronous, active high) restores segment 0 as the only used
// segment, with slot 0 live and holding the summary, clears the out of space
// flag and drops rsp.valid. No clearing pass is needed, because only the
// current segment's liveness row is ever consulted.
// ----------------------------------------------------------------------------
module log_segment_block_allocator import lsba_pkg::*; #(
  parameter int SLOTS_PER_SEGMENT = SLOTS_PER_SEGMENT_DEF,
  parameter int SEGMENT_COUNT     = SEGMENT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lsba_req_if.sink    req,
  lsba_rsp_if.source  rsp
);

  // Limits for the range check on the old home.
  localparam logic [SEG_FIELD_W:0] SEG_LIMIT  = (SEG_FIELD_W + 1)'(SEGMENT_COUNT);
  localparam logic [SLOT_IDX_W:0]  SLOT_LIMIT = (SLOT_IDX_W + 1)'(SLOTS_PER_SEGMENT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLK_FIND,
    S_BLK_APPLY,
    S_SUM_FIND,
    S_SUM_APPLY,
    S_RESULT
  } state_t;

  state_t                  st;
  logic                    has_old;
  logic [SEG_FIELD_W-1:0]  old_segment;
  logic [SLOT_FIELD_W-1:0] old_slot;
  logic [SEG_FIELD_W-1:0]  sum_seg;
  logic [SLOT_FIELD_W-1:0] sum_slot;
  logic                    oos;
  status_t                 res_status;
  logic [SEG_FIELD_W-1:0]  res_seg;
  logic [SLOT_FIELD_W-1:0] res_slot;
  logic                    res_switched;
  logic                    rsp_valid;
  status_t                 rsp_status;
  logic [SEG_FIELD_W-1:0]  rsp_seg;
  logic [SLOT_FIELD_W-1:0] rsp_slot;
  logic [SEG_FIELD_W-1:0]  rsp_sum_seg;
  logic [SLOT_FIELD_W-1:0] rsp_sum_slot;
  logic                    rsp_switched;
  logic                    old_ok;
  unit_cmd_t               ucmd;
  unit_res_t               ures;

  // An old home outside the log counts as no old home at all.
  assign old_ok = req.has_old &&
                  ({1'b0, req.old_segment} < SEG_LIMIT) &&
                  ({2'b00, req.old_slot} < SLOT_LIMIT);

  assign req.ready = (st == S_IDLE);

  // The block's own placement runs first; the summary block follows with its
  // current location as the old home, always through the same unit.
  always_comb begin
    ucmd.op          = UNIT_NOP;
    ucmd.has_old     = has_old;
    ucmd.old_segment = old_segment;
    ucmd.old_slot    = old_slot;
    case (st)
      S_BLK_FIND:  ucmd.op = UNIT_FIND;
      S_BLK_APPLY: ucmd.op = UNIT_APPLY;
      S_SUM_FIND,
      S_SUM_APPLY: begin
        ucmd.op          = (st == S_SUM_FIND) ? UNIT_FIND : UNIT_APPLY;
        ucmd.has_old     = 1'b1;
        ucmd.old_segment = sum_seg;
        ucmd.old_slot    = sum_slot;
      end
      default: begin
      end
    endcase
  end

  lsba_slot_unit #(
    .SLOTS_PER_SEGMENT (SLOTS_PER_SEGMENT),
    .SEGMENT_COUNT     (SEGMENT_COUNT)
  ) u_slot (
    .clk (clk),
    .rst (rst),
    .cmd (ucmd),
    .res (ures)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      sum_seg   <= '0;
      sum_slot  <= '0;
      oos       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // In the result state the load below decides rsp_valid on its own.
      if (rsp_valid && rsp.ready && st != S_RESULT) begin
        rsp_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (req.valid) begin
            has_old     <= old_ok;
            old_segment <= req.old_segment;
            old_slot    <= req.old_slot;
            if (oos) begin
              // Once the log is exhausted nothing changes until reset.
              res_status   <= STATUS_NO_SPACE;
              res_seg      <= '0;
              res_slot     <= '0;
              res_switched <= 1'b0;
              st           <= S_RESULT;
            end else begin
              st <= S_BLK_FIND;
            end
          end
        end
        S_BLK_FIND: st <= S_BLK_APPLY;
        S_BLK_APPLY: begin
          res_switched <= 1'b0;
          if (ures.hit) begin
            res_status <= STATUS_REWRITTEN;
            res_seg    <= old_segment;
            res_slot   <= old_slot;
            st         <= S_RESULT;
          end else if (ures.found) begin
            res_status <= STATUS_PLACED;
            res_seg    <= ures.cur_seg;
            res_slot   <= ures.free_idx[SLOT_FIELD_W-1:0];
            st         <= S_SUM_FIND;
          end else if (!ures.last) begin
            res_status   <= STATUS_PLACED;
            res_seg      <= ures.cur_seg + 1'b1;
            res_slot     <= '0;
            res_switched <= 1'b1;
            st           <= S_SUM_FIND;
          end else begin
            oos        <= 1'b1;
            res_status <= STATUS_NO_SPACE;
            res_seg    <= '0;
            res_slot   <= '0;
            st         <= S_RESULT;
          end
        end
        S_SUM_FIND: st <= S_SUM_APPLY;
        S_SUM_APPLY: begin
          // A summary rewritten in place keeps its location.
          if (!ures.hit) begin
            if (ures.found) begin
              sum_seg  <= ures.cur_seg;
              sum_slot <= ures.free_idx[SLOT_FIELD_W-1:0];
            end else if (!ures.last) begin
              sum_seg      <= ures.cur_seg + 1'b1;
              sum_slot     <= '0;
              res_switched <= 1'b1;
            end else begin
              // The block keeps its new home; only the summary found no room.
              oos        <= 1'b1;
              res_status <= STATUS_NO_SPACE;
            end
          end
          st <= S_RESULT;
        end
        S_RESULT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            rsp_status   <= res_status;
            rsp_seg      <= res_seg;
            rsp_slot     <= res_slot;
            rsp_sum_seg  <= sum_seg;
            rsp_sum_slot <= sum_slot;
            rsp_switched <= res_switched;
            st           <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.status           = rsp_status;
  assign rsp.block_segment    = rsp_seg;
  assign rsp.block_slot       = rsp_slot;
  assign rsp.summary_segment  = rsp_sum_seg;
  assign rsp.summary_slot     = rsp_sum_slot;
  assign rsp.segment_switched = rsp_switched;

endmodule

// File: design/lsba_checker.sv
// ----------------------------------------------------------------------------
// lsba_checker
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "log_segment_block_allocator_assert.svh"

module lsba_checker import lsba_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input status_t                 rsp_status,
  input logic [SEG_FIELD_W-1:0]  rsp_block_segment,
  input logic [SLOT_FIELD_W-1:0] rsp_block_slot,
  input logic [SEG_FIELD_W-1:0]  rsp_summary_segment,
  input logic [SLOT_FIELD_W-1:0] rsp_summary_slot,
  input logic                    rsp_segment_switched
);

  // A stalled response keeps its valid and its payload.
  `LSBA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable({rsp_status, rsp_block_segment, rsp_block_slot,
                          rsp_summary_segment, rsp_summary_slot, rsp_segment_switched}))

  // Requests are serviced one at a time.
  `LSBA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)

  // Only a new placement can claim a new segment.
  `LSBA_ASSERT_NOW(a_switch_only_placed, clk, rst,
    rsp_valid && rsp_status != STATUS_PLACED, !rsp_segment_switched)

  // Reset drops any pending response.
  `LSBA_ASSERT_NEXT(a_reset_clears_rsp, clk, 1'b0, rst, !rsp_valid)

endmodule

bind log_segment_block_allocator lsba_checker u_lsba_checker (
  .clk                  (clk),
  .rst                  (rst),
  .req_valid            (req.valid),
  .req_ready            (req.ready),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_status           (rsp.status),
  .rsp_block_segment    (rsp.block_segment),
  .rsp_block_slot       (rsp.block_slot),
  .rsp_summary_segment  (rsp.summary_segment),
  .rsp_summary_slot     (rsp.summary_slot),
  .rsp_segment_switched (rsp.segment_switched)
);

// File: dv/log_segment_block_allocator_test.sv
// ----------------------------------------------------------------------------
// log_segment_block_allocator_test
// Self-checking bench for the log segment block allocator. A short table of
// directed placements is followed by random file traffic that crosses a
// number of segment switches. Every response is compared field by field
// against the fixed answer of its directed row or else an in-bench model of the log.
// ----------------------------------------------------------------------------
module log_segment_block_allocator_test import lsba_pkg::*; ();

  localparam int SLOTS       = SLOTS_PER_SEGMENT_DEF;
  localparam int SEGS        = SEGMENT_COUNT_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 40;
  // The run is under five hundred requests, even with the longest gaps on
  // both sides; this limit is several times what such a run needs.
  localparam int CYCLE_LIMIT = 200000;

  // Liveness of one slot as the log sees it.
  typedef enum logic [1:0] {
    SLOT_FREE   = 2'd0,
    SLOT_LIVE   = 2'd1,
    SLOT_SEALED = 2'd2
  } slot_state_t;

  // Outcome of placing one block, either the user's or the summary.
  typedef enum logic [1:0] {
    PLACE_MOVED,
    PLACE_IN_PLACE,
    PLACE_NO_ROOM
  } place_t;

  typedef struct packed {
    status_t                 status;
    logic [SEG_FIELD_W-1:0]  block_segment;
    logic [SLOT_FIELD_W-1:0] block_slot;
    logic [SEG_FIELD_W-1:0]  summary_segment;
    logic [SLOT_FIELD_W-1:0] summary_slot;
    logic                    segment_switched;
  } placement_t;

  typedef struct packed {
    logic [SEG_FIELD_W-1:0]  seg;
    logic [SLOT_FIELD_W-1:0] slot;
  } home_t;

  typedef struct packed {
    logic                    has_old;
    logic [SEG_FIELD_W-1:0]  old_segment;
    logic [SLOT_FIELD_W-1:0] old_slot;
    logic                    fixed;
    placement_t              answer;
  } probe_row_t;

  localparam placement_t ASK_MODEL = '{STATUS_PLACED, 6'd0, 5'd0, 6'd0, 5'd0, 1'b0};

  // Directed opening. Rows with fixed set carry an answer that follows from
  // the reset state by hand; the others are left to the log model.
  localparam probe_row_t PROBE_ROWS [16] = '{
    // A brand new block lands in the first free slot after the summary.
    '{1'b0, 6'd0,  5'd0,  1'b1, '{STATUS_PLACED,    6'd0, 5'd1, 6'd0, 5'd0, 1'b0}},
    // Its home is live and unflushed in the open segment: rewritten there.
    '{1'b1, 6'd0,  5'd1,  1'b1, '{STATUS_REWRITTEN, 6'd0, 5'd1, 6'd0, 5'd0, 1'b0}},
    // An old home on top of the summary slot is also rewritten in place.
    '{1'b1, 6'd0,  5'd0,  1'b1, '{STATUS_REWRITTEN, 6'd0, 5'd0, 6'd0, 5'd0, 1'b0}},
    // Slot index past the segment end counts as no old home at all.
    '{1'b1, 6'd0,  5'd31, 1'b1, '{STATUS_PLACED,    6'd0, 5'd2, 6'd0, 5'd0, 1'b0}},
    // Old home fields are ignored when has_old is low, even all ones.
    '{1'b0, 6'd63, 5'd31, 1'b1, '{STATUS_PLACED,    6'd0, 5'd3, 6'd0, 5'd0, 1'b0}},
    // Highest in-range home, in an unused segment: a plain move.
    '{1'b1, 6'd63, 5'd30, 1'b1, '{STATUS_PLACED,    6'd0, 5'd4, 6'd0, 5'd0, 1'b0}},
    // Old home is the very slot that gets picked, so it ends up free again.
    '{1'b1, 6'd0,  5'd5,  1'b1, '{STATUS_PLACED,    6'd0, 5'd5, 6'd0, 5'd0, 1'b0}},
    // ...and the next new block reuses it.
    '{1'b0, 6'd0,  5'd0,  1'b1, '{STATUS_PLACED,    6'd0, 5'd5, 6'd0, 5'd0, 1'b0}},
    '{1'b1, 6'd0,  5'd20, 1'b0, ASK_MODEL},
    '{1'b1, 6'd1,  5'd0,  1'b0, ASK_MODEL},
    '{1'b1, 6'd0,  5'd30, 1'b0, ASK_MODEL},
    '{1'b1, 6'd0,  5'd7,  1'b0, ASK_MODEL},
    '{1'b1, 6'd42, 5'd31, 1'b0, ASK_MODEL},
    '{1'b1, 6'd0,  5'd3,  1'b0, ASK_MODEL},
    '{1'b1, 6'd21, 5'd10, 1'b0, ASK_MODEL},
    '{1'b1, 6'd42, 5'd21, 1'b0, ASK_MODEL}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  lsba_req_if req ();
  lsba_rsp_if rsp ();

  log_segment_block_allocator #(
    .SLOTS_PER_SEGMENT(SLOTS),
    .SEGMENT_COUNT    (SEGS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Expected responses, oldest first, and the failure tally.
  placement_t pending_placements [$];
  int         mismatches = 0;
  int         cycle_count = 0;

  // While steady_flow is set neither side inserts idle cycles.
  bit         steady_flow = 1'b0;

  // Homes of the blocks the bench treats as its files, so that most traffic
  // rewrites or relocates real blocks instead of random addresses.
  home_t      file_homes [$];

  // --------------------------------------------------------------------------
  // Log model: slot liveness per segment, segment usage, the open segment,
  // the summary location and the sticky out of space flag.
  // --------------------------------------------------------------------------
  slot_state_t     slot_map [SEGS][SLOTS];
  bit [SEGS-1:0]   segs_taken;
  int              active_seg;
  int              summary_seg;
  int              summary_slot;
  bit              log_full;
  bit              switched_now;

  function automatic void reset_log_model();
    for (int s = 0; s < SEGS; s++)
      for (int i = 0; i < SLOTS; i++)
        slot_map[s][i] = SLOT_FREE;
    slot_map[0][0] = SLOT_LIVE;
    segs_taken     = SEGS'(1);
    active_seg     = 0;
    summary_seg    = 0;
    summary_slot   = 0;
    log_full       = 1'b0;
    switched_now   = 1'b0;
  endfunction

  function automatic int first_open_slot();
    for (int i = 0; i < SLOTS; i++)
      if (slot_map[active_seg][i] == SLOT_FREE) return i;
    return -1;
  endfunction

  // Places one block. A live, unflushed home in the open segment is reused;
  // otherwise the first free slot is taken, sealing the segment and opening
  // the lowest unused one when it is full, and the old home is released.
  function automatic place_t settle_block(input bit moving, input int from_seg,
                                          input int from_slot, output int to_seg,
                                          output int to_slot);
    int idx;
    to_seg  = 0;
    to_slot = 0;
    if (moving && from_seg == active_seg && slot_map[from_seg][from_slot] == SLOT_LIVE) begin
      to_seg  = from_seg;
      to_slot = from_slot;
      return PLACE_IN_PLACE;
    end
    idx = first_open_slot();
    if (idx < 0) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_map[active_seg][i] == SLOT_LIVE) slot_map[active_seg][i] = SLOT_SEALED;
      idx = -1;
      for (int s = 0; s < SEGS && idx < 0; s++) begin
        if (!segs_taken[s]) begin
          segs_taken[s] = 1'b1;
          active_seg    = s;
          idx           = 0;
        end
      end
      if (idx < 0) return PLACE_NO_ROOM;
      switched_now = 1'b1;
    end
    slot_map[active_seg][idx] = SLOT_LIVE;
    // Released after the new slot is claimed, so a home equal to the new
    // slot ends up free.
    if (moving) slot_map[from_seg][from_slot] = SLOT_FREE;
    to_seg  = active_seg;
    to_slot = idx;
    return PLACE_MOVED;
  endfunction

  // Applies one request to the log model and returns the response it owes.
  function automatic placement_t predict_placement(input logic has_old,
                                                   input logic [SEG_FIELD_W-1:0] old_seg,
                                                   input logic [SLOT_FIELD_W-1:0] old_slot);
    placement_t r;
    bit         moving;
    int         bs, bl, ss, sl;
    place_t     how;
    moving = has_old;
    if (old_seg >= SEGS || old_slot >= SLOTS) moving = 1'b0;
    switched_now = 1'b0;
    bs = 0;
    bl = 0;
    r.status = STATUS_NO_SPACE;
    if (!log_full) begin
      how = settle_block(moving, int'(old_seg), int'(old_slot), bs, bl);
      if (how == PLACE_NO_ROOM) begin
        // The block found no segment: nothing is freed, location reads zero.
        log_full = 1'b1;
        bs = 0;
        bl = 0;
      end else if (how == PLACE_IN_PLACE) begin
        r.status = STATUS_REWRITTEN;
      end else begin
        // The summary follows every new placement, its old home being the
        // current summary location.
        how = settle_block(1'b1, summary_seg, summary_slot, ss, sl);
        if (how == PLACE_NO_ROOM) begin
          log_full = 1'b1;
        end else begin
          summary_seg  = ss;
          summary_slot = sl;
          r.status     = STATUS_PLACED;
        end
      end
    end
    r.block_segment    = bs[SEG_FIELD_W-1:0];
    r.block_slot       = bl[SLOT_FIELD_W-1:0];
    r.summary_segment  = summary_seg[SEG_FIELD_W-1:0];
    r.summary_slot     = summary_slot[SLOT_FIELD_W-1:0];
    r.segment_switched = switched_now;
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Fields change only at a rising edge; a transaction counts
  // at the edge where valid and ready are both high. The model is advanced
  // at that edge, so expectations stay in acceptance order.
  // --------------------------------------------------------------------------
  task automatic issue_request(input logic has_old, input logic [SEG_FIELD_W-1:0] old_seg,
                               input logic [SLOT_FIELD_W-1:0] old_slot, input bit fixed,
                               input placement_t answer, output placement_t got);
    placement_t predicted;
    int         gap;
    req.valid       <= 1'b1;
    req.has_old     <= has_old;
    req.old_segment <= old_seg;
    req.old_slot    <= old_slot;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = predict_placement(has_old, old_seg, old_slot);
    pending_placements.push_back(fixed ? answer : predicted);
    got = predicted;
    // valid stays high straight into the next request when there is no gap.
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the request side until every outstanding response has come back.
  // With nothing outstanding, valid is already low from an earlier gap.
  task automatic wait_drained();
    if (pending_placements.size() != 0) begin
      req.valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clk);
    end
  endtask

  // One random request shaped like file system traffic. new_pct sets the
  // share of brand new blocks; the rest mostly rewrite or relocate known
  // files, with a few aimed at the next free slot, at the summary location,
  // or anywhere at all.
  task automatic random_request(input int new_pct);
    placement_t                got;
    logic                      has_old;
    logic [SEG_FIELD_W-1:0]    old_seg;
    logic [SLOT_FIELD_W-1:0]   old_slot;
    int                        pick;
    int                        kind;
    int                        idx;
    int                        free_idx;
    idx      = -1;
    has_old  = 1'b1;
    old_seg  = SEG_FIELD_W'($urandom_range(0, 63));
    old_slot = SLOT_FIELD_W'($urandom_range(0, 31));
    pick     = $urandom_range(0, 99);
    kind     = $urandom_range(0, 9);
    if (pick < new_pct || file_homes.size() == 0) begin
      // The old home fields carry noise that must be ignored.
      has_old = 1'b0;
    end else if (kind < 6) begin
      idx      = $urandom_range(0, file_homes.size() - 1);
      old_seg  = file_homes[idx].seg;
      old_slot = file_homes[idx].slot;
    end else if (kind == 6) begin
      free_idx = first_open_slot();
      old_seg  = SEG_FIELD_W'(active_seg);
      old_slot = (free_idx < 0) ? '0 : SLOT_FIELD_W'(free_idx);
    end else if (kind == 7) begin
      old_seg  = SEG_FIELD_W'(summary_seg);
      old_slot = SLOT_FIELD_W'(summary_slot);
    end else begin
      has_old = 1'($urandom_range(0, 1));
    end
    issue_request(has_old, old_seg, old_slot, 1'b0, ASK_MODEL, got);
    if (got.status == STATUS_PLACED) begin
      if (!has_old) begin
        file_homes.push_back('{got.block_segment, got.block_slot});
        if (file_homes.size() > 40) file_homes.delete($urandom_range(0, file_homes.size() - 1));
      end else if (idx >= 0) begin
        file_homes[idx] = '{got.block_segment, got.block_slot};
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side: random back-pressure, and every response transaction is
  // checked against the oldest expectation.
  // --------------------------------------------------------------------------
  initial begin
    int         stall_left;
    placement_t want;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (pending_placements.size() == 0) begin
          $error("response transaction with no request outstanding");
          mismatches++;
        end else begin
          want = pending_placements.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.block_segment !== want.block_segment) begin
            $error("block_segment: expected %0d, got %0d", want.block_segment,
                   rsp.block_segment);
            mismatches++;
          end
          if (rsp.block_slot !== want.block_slot) begin
            $error("block_slot: expected %0d, got %0d", want.block_slot, rsp.block_slot);
            mismatches++;
          end
          if (rsp.summary_segment !== want.summary_segment) begin
            $error("summary_segment: expected %0d, got %0d", want.summary_segment,
                   rsp.summary_segment);
            mismatches++;
          end
          if (rsp.summary_slot !== want.summary_slot) begin
            $error("summary_slot: expected %0d, got %0d", want.summary_slot,
                   rsp.summary_slot);
            mismatches++;
          end
          if (rsp.segment_switched !== want.segment_switched) begin
            $error("segment_switched: expected %0d, got %0d", want.segment_switched,
                   rsp.segment_switched);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: a hang or a lost response ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed table, then random traffic.
  // --------------------------------------------------------------------------
  initial begin
    placement_t got;
    req.valid       <= 1'b0;
    req.has_old     <= 1'b0;
    req.old_segment <= '0;
    req.old_slot    <= '0;
    reset_log_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (PROBE_ROWS[i])
      issue_request(PROBE_ROWS[i].has_old, PROBE_ROWS[i].old_segment,
                    PROBE_ROWS[i].old_slot, PROBE_ROWS[i].fixed,
                    PROBE_ROWS[i].answer, got);
    // Let the pipeline empty completely once before the random traffic.
    wait_drained();

    // Random traffic crosses about ten segment switches. Every forty
    // requests the bench may switch to a stretch without any idling.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 59) == 0) wait_drained();
      random_request(35);
    end
    steady_flow = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
